>>> design/ssd_pkg.sv
// shared types, widths and step functions of the segment distance pipeline
// no dependencies; used by segment_segment_distance, ssd_div and ssd_isqrt
package ssd_pkg;

	// port and arithmetic widths
	localparam int IN_W       = 16;
	localparam int OUT_W      = 25;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int LANES      = 4;

	localparam int DIFF_W = COORD_BITS + 1;          // coordinate difference, signed
	localparam int PROD_W = 2 * DIFF_W;              // product of two differences, signed
	localparam int CRS_W  = PROD_W + 1;              // cross or dot product, signed
	localparam int SQ_W   = 2 * COORD_BITS + 1;      // squared length or |cross|, unsigned
	localparam int LO_W   = (SQ_W + 1) / 2;          // low half of |cross| for squaring
	localparam int HI_W   = SQ_W - LO_W;
	localparam int C2_W   = 2 * SQ_W;                // cross squared
	localparam int NUM_W  = C2_W + 2 * FRAC_BITS;    // scaled dividend
	localparam int QW     = SQ_W + 2 * FRAC_BITS;    // scaled squared distance
	localparam int RW     = (QW + 1) / 2;            // root bits
	localparam int OP_W   = 2 * RW;                  // radicand padded to whole digit pairs
	localparam int SR_W   = RW + 2;                  // root remainder
	localparam int LAT    = QW + 2 + RW;             // stages behind the divider inputs

	// per lane differences: segment direction, point to start, point to end
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] vx;
		logic signed [DIFF_W-1:0] vy;
		logic signed [DIFF_W-1:0] wx;
		logic signed [DIFF_W-1:0] wy;
	} lane_diff_t;

	// per lane products
	typedef struct packed {
		logic signed [PROD_W-1:0] cra;
		logic signed [PROD_W-1:0] crb;
		logic signed [PROD_W-1:0] dxx;
		logic signed [PROD_W-1:0] dyy;
		logic signed [PROD_W-1:0] vxx;
		logic signed [PROD_W-1:0] vyy;
		logic signed [PROD_W-1:0] wxx;
		logic signed [PROD_W-1:0] wyy;
		logic signed [PROD_W-1:0] tdx;
		logic signed [PROD_W-1:0] tdy;
		logic                     box;
	} lane_prod_t;

	// per lane sums
	typedef struct packed {
		logic signed [CRS_W-1:0] crs;
		logic signed [CRS_W-1:0] dot;
		logic [SQ_W-1:0]         len2;
		logic [SQ_W-1:0]         ev;
		logic [SQ_W-1:0]         ew;
		logic                    box;
	} lane_sum_t;

	// per lane distance candidate before squaring the cross product
	typedef struct packed {
		logic [SQ_W-1:0] mag;
		logic [SQ_W-1:0] e2;
		logic [SQ_W-1:0] len2;
		logic            perp;
	} lane_sel_t;

	// per lane partial products of the cross product square
	typedef struct packed {
		logic [2*LO_W-1:0]    pll;
		logic [HI_W+LO_W-1:0] phl;
		logic [2*HI_W-1:0]    phh;
		logic [SQ_W-1:0]      e2;
		logic [SQ_W-1:0]      len2;
		logic                 perp;
	} lane_part_t;

	// control that travels with each transaction
	typedef struct packed {
		logic valid;
		logic touch;
	} ctl_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [QW-1:0]   qn;
	} div_t;

	typedef struct packed {
		logic [SR_W-1:0] rem;
		logic [RW-1:0]   root;
	} sqrt_t;

	// difference of two coordinates taken from the low coordinate bits
	function automatic logic signed [DIFF_W-1:0] sub_c(input logic [IN_W-1:0] a,
			input logic [IN_W-1:0] b);
		logic signed [COORD_BITS-1:0] sa;
		logic signed [COORD_BITS-1:0] sb;
		sa = a[COORD_BITS-1:0];
		sb = b[COORD_BITS-1:0];
		return DIFF_W'(sa) - DIFF_W'(sb);
	endfunction

	// differences for point p against segment a to b
	function automatic lane_diff_t lane_diff(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
			input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
			input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by);
		lane_diff_t r;
		r.dx = sub_c(bx, ax);
		r.dy = sub_c(by, ay);
		r.vx = sub_c(px, ax);
		r.vy = sub_c(py, ay);
		r.wx = sub_c(px, bx);
		r.wy = sub_c(py, by);
		return r;
	endfunction

	// one restoring division step, one quotient bit
	function automatic div_t div_step(input logic [SQ_W-1:0] rem, input logic [QW-1:0] qn,
			input logic [SQ_W-1:0] den);
		logic [SQ_W:0] sh;
		logic [SQ_W:0] diff;
		div_t r;
		sh   = {rem, qn[QW-1]};
		diff = sh - {1'b0, den};
		if (sh >= {1'b0, den}) begin
			r.rem = diff[SQ_W-1:0];
			r.qn  = {qn[QW-2:0], 1'b1};
		end else begin
			r.rem = sh[SQ_W-1:0];
			r.qn  = {qn[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	// one digit-by-digit square root step, one root bit per digit pair
	function automatic sqrt_t sqrt_step(input logic [SR_W-1:0] rem, input logic [RW-1:0] root,
			input logic [1:0] pair);
		logic [SR_W+1:0] sh;
		logic [SR_W+1:0] trial;
		logic [SR_W+1:0] diff;
		sqrt_t r;
		sh    = {rem, pair};
		trial = {2'b00, root, 2'b01};
		diff  = sh - trial;
		if (sh >= trial) begin
			r.rem  = diff[SR_W-1:0];
			r.root = {root[RW-2:0], 1'b1};
		end else begin
			r.rem  = sh[SR_W-1:0];
			r.root = {root[RW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> design/ssd_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ssd_pkg
module ssd_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ssd_pkg::SQ_W-1:0] rem_in,
	input  logic [ssd_pkg::QW-1:0]   qn_in,
	input  logic [ssd_pkg::SQ_W-1:0] den_in,
	output logic [ssd_pkg::QW-1:0]   quo
);

	logic [ssd_pkg::SQ_W-1:0] rem_s [1:ssd_pkg::QW];
	logic [ssd_pkg::QW-1:0]   qn_s  [1:ssd_pkg::QW];
	logic [ssd_pkg::SQ_W-1:0] den_s [1:ssd_pkg::QW];

	// stage chain, the low dividend bits shift out as quotient bits shift in
	for (genvar i = 1; i <= ssd_pkg::QW; i++) begin : g_stage
		ssd_pkg::div_t            nxt;
		logic [ssd_pkg::SQ_W-1:0] den_p;
		if (i == 1) begin : g_first
			assign nxt   = ssd_pkg::div_step(rem_in, qn_in, den_in);
			assign den_p = den_in;
		end else begin : g_rest
			assign nxt   = ssd_pkg::div_step(rem_s[i-1], qn_s[i-1], den_s[i-1]);
			assign den_p = den_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= nxt.rem;
				qn_s[i]  <= nxt.qn;
				den_s[i] <= den_p;
			end
		end
	end

	assign quo = qn_s[ssd_pkg::QW];

endmodule

>>> design/ssd_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on ssd_pkg
module ssd_isqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ssd_pkg::OP_W-1:0] op,
	output logic [ssd_pkg::RW-1:0]   root
);

	logic [ssd_pkg::SR_W-1:0] rem_s  [1:ssd_pkg::RW];
	logic [ssd_pkg::RW-1:0]   root_s [1:ssd_pkg::RW];
	logic [ssd_pkg::OP_W-1:0] op_s   [1:ssd_pkg::RW];

	// each stage takes the top digit pair of the remaining radicand
	for (genvar i = 1; i <= ssd_pkg::RW; i++) begin : g_stage
		ssd_pkg::sqrt_t           nxt;
		logic [ssd_pkg::OP_W-1:0] op_p;
		if (i == 1) begin : g_first
			assign op_p = op;
			assign nxt  = ssd_pkg::sqrt_step('0, '0, op[ssd_pkg::OP_W-1 -: 2]);
		end else begin : g_rest
			assign op_p = op_s[i-1];
			assign nxt  = ssd_pkg::sqrt_step(rem_s[i-1], root_s[i-1],
				op_s[i-1][ssd_pkg::OP_W-1 -: 2]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= nxt.rem;
				root_s[i] <= nxt.root;
				op_s[i]   <= {op_p[ssd_pkg::OP_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[ssd_pkg::RW];

endmodule

>>> design/segment_segment_distance.sv
// top level: distance between two 2D segments, fully pipelined
// depends on ssd_pkg, ssd_div and ssd_isqrt
//
//   channel  handshake             payload
//   req      req_valid/req_ready   seg_a_*, seg_b_* endpoint coordinates
//   rsp      rsp_valid/rsp_ready   distance, touching
//
// one transaction enters per cycle while rsp is not stalled
// pipeline: 6 front stages, one divider stage per quotient bit (49),
// 2 minimum stages and one square root stage per root bit (25)
// reset clears only the valid bits and the control line; data registers are not reset
// a stall on rsp freezes the whole pipeline, req_ready follows it
module segment_segment_distance (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [ssd_pkg::IN_W-1:0]  seg_a_start_x,
	input  logic [ssd_pkg::IN_W-1:0]  seg_a_start_y,
	input  logic [ssd_pkg::IN_W-1:0]  seg_a_end_x,
	input  logic [ssd_pkg::IN_W-1:0]  seg_a_end_y,
	input  logic [ssd_pkg::IN_W-1:0]  seg_b_start_x,
	input  logic [ssd_pkg::IN_W-1:0]  seg_b_start_y,
	input  logic [ssd_pkg::IN_W-1:0]  seg_b_end_x,
	input  logic [ssd_pkg::IN_W-1:0]  seg_b_end_y,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [ssd_pkg::OUT_W-1:0] distance,
	output logic                      touching
);

	localparam int L = ssd_pkg::LANES;

	logic adv;

	ssd_pkg::lane_diff_t dif_c [L];
	ssd_pkg::lane_diff_t dif_s1 [L];
	ssd_pkg::lane_prod_t prd_c [L];
	ssd_pkg::lane_prod_t prd_s2 [L];
	ssd_pkg::lane_sum_t  sum_c [L];
	ssd_pkg::lane_sum_t  sum_s3 [L];
	ssd_pkg::lane_sel_t  sel_c [L];
	ssd_pkg::lane_sel_t  sel_s4 [L];
	ssd_pkg::lane_part_t prt_c [L];
	ssd_pkg::lane_part_t prt_s5 [L];

	logic [ssd_pkg::SQ_W-1:0] rem_c  [L];
	logic [ssd_pkg::QW-1:0]   qn_c   [L];
	logic [ssd_pkg::SQ_W-1:0] den_c  [L];
	logic [ssd_pkg::SQ_W-1:0] rem_s6 [L];
	logic [ssd_pkg::QW-1:0]   qn_s6  [L];
	logic [ssd_pkg::SQ_W-1:0] den_s6 [L];
	logic [ssd_pkg::QW-1:0]   quo    [L];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic touch_c, touch_s4, touch_s5, touch_s6;
	logic [L-1:0] neg, zero;

	logic [ssd_pkg::QW-1:0] min01_sm1, min23_sm1, min_sm2;
	logic [ssd_pkg::RW-1:0] root;

	ssd_pkg::ctl_t ctl_s [ssd_pkg::LAT];

	// whole pipeline moves unless a finished result is held
	assign adv       = ~rsp_valid | rsp_ready;
	assign req_ready = adv;

	// lanes: each endpoint against the other segment
	assign dif_c[0] = ssd_pkg::lane_diff(seg_a_start_x, seg_a_start_y,
		seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y);
	assign dif_c[1] = ssd_pkg::lane_diff(seg_a_end_x, seg_a_end_y,
		seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y);
	assign dif_c[2] = ssd_pkg::lane_diff(seg_b_start_x, seg_b_start_y,
		seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y);
	assign dif_c[3] = ssd_pkg::lane_diff(seg_b_end_x, seg_b_end_y,
		seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y);

	for (genvar k = 0; k < L; k++) begin : g_lane
		logic box_x, box_y;
		logic signed [ssd_pkg::CRS_W-1:0] dot_m_len;
		logic [ssd_pkg::CRS_W-1:0]        crs_abs;
		logic [ssd_pkg::C2_W-1:0]         c2;
		logic [ssd_pkg::NUM_W-1:0]        num;
		logic [ssd_pkg::LO_W-1:0]         lo;
		logic [ssd_pkg::HI_W-1:0]         hi;

		// stage 2: products, point inside the segment's bounding box
		assign box_x = ((dif_s1[k].vx[ssd_pkg::DIFF_W-1] | (dif_s1[k].vx == '0))
				& ~dif_s1[k].wx[ssd_pkg::DIFF_W-1])
			| (~dif_s1[k].vx[ssd_pkg::DIFF_W-1]
				& (dif_s1[k].wx[ssd_pkg::DIFF_W-1] | (dif_s1[k].wx == '0)));
		assign box_y = ((dif_s1[k].vy[ssd_pkg::DIFF_W-1] | (dif_s1[k].vy == '0))
				& ~dif_s1[k].wy[ssd_pkg::DIFF_W-1])
			| (~dif_s1[k].vy[ssd_pkg::DIFF_W-1]
				& (dif_s1[k].wy[ssd_pkg::DIFF_W-1] | (dif_s1[k].wy == '0)));
		assign prd_c[k].cra = dif_s1[k].dx * dif_s1[k].vy;
		assign prd_c[k].crb = dif_s1[k].dy * dif_s1[k].vx;
		assign prd_c[k].dxx = dif_s1[k].dx * dif_s1[k].dx;
		assign prd_c[k].dyy = dif_s1[k].dy * dif_s1[k].dy;
		assign prd_c[k].vxx = dif_s1[k].vx * dif_s1[k].vx;
		assign prd_c[k].vyy = dif_s1[k].vy * dif_s1[k].vy;
		assign prd_c[k].wxx = dif_s1[k].wx * dif_s1[k].wx;
		assign prd_c[k].wyy = dif_s1[k].wy * dif_s1[k].wy;
		assign prd_c[k].tdx = dif_s1[k].vx * dif_s1[k].dx;
		assign prd_c[k].tdy = dif_s1[k].vy * dif_s1[k].dy;
		assign prd_c[k].box = box_x & box_y;

		// stage 3: cross, dot and squared lengths
		assign sum_c[k].crs  = ssd_pkg::CRS_W'(prd_s2[k].cra) - ssd_pkg::CRS_W'(prd_s2[k].crb);
		assign sum_c[k].dot  = ssd_pkg::CRS_W'(prd_s2[k].tdx) + ssd_pkg::CRS_W'(prd_s2[k].tdy);
		assign sum_c[k].len2 = ssd_pkg::SQ_W'(ssd_pkg::CRS_W'(prd_s2[k].dxx)
			+ ssd_pkg::CRS_W'(prd_s2[k].dyy));
		assign sum_c[k].ev   = ssd_pkg::SQ_W'(ssd_pkg::CRS_W'(prd_s2[k].vxx)
			+ ssd_pkg::CRS_W'(prd_s2[k].vyy));
		assign sum_c[k].ew   = ssd_pkg::SQ_W'(ssd_pkg::CRS_W'(prd_s2[k].wxx)
			+ ssd_pkg::CRS_W'(prd_s2[k].wyy));
		assign sum_c[k].box  = prd_s2[k].box;

		// stage 4: foot position, nearer endpoint or perpendicular
		assign neg[k]    = sum_s3[k].crs[ssd_pkg::CRS_W-1];
		assign zero[k]   = (sum_s3[k].crs == '0);
		assign dot_m_len = sum_s3[k].dot
			- ssd_pkg::CRS_W'($signed({1'b0, sum_s3[k].len2}));
		assign crs_abs   = neg[k] ? -sum_s3[k].crs : sum_s3[k].crs;
		always_comb begin
			sel_c[k].mag  = crs_abs[ssd_pkg::SQ_W-1:0];
			sel_c[k].len2 = sum_s3[k].len2;
			sel_c[k].perp = 1'b0;
			if ((sum_s3[k].len2 == '0) || sum_s3[k].dot[ssd_pkg::CRS_W-1]
					|| (sum_s3[k].dot == '0)) begin
				sel_c[k].e2 = sum_s3[k].ev;
			end else if (~dot_m_len[ssd_pkg::CRS_W-1]) begin
				sel_c[k].e2 = sum_s3[k].ew;
			end else begin
				sel_c[k].e2   = sum_s3[k].ev;
				sel_c[k].perp = 1'b1;
			end
		end

		// stage 5: partial products of the cross square
		assign lo = sel_s4[k].mag[ssd_pkg::LO_W-1:0];
		assign hi = sel_s4[k].mag[ssd_pkg::SQ_W-1:ssd_pkg::LO_W];
		assign prt_c[k].pll  = lo * lo;
		assign prt_c[k].phl  = hi * lo;
		assign prt_c[k].phh  = hi * hi;
		assign prt_c[k].e2   = sel_s4[k].e2;
		assign prt_c[k].len2 = sel_s4[k].len2;
		assign prt_c[k].perp = sel_s4[k].perp;

		// stage 6: scaled dividend and divisor
		assign c2 = (ssd_pkg::C2_W'(prt_s5[k].phh) << (2 * ssd_pkg::LO_W))
			+ (ssd_pkg::C2_W'(prt_s5[k].phl) << (ssd_pkg::LO_W + 1))
			+ ssd_pkg::C2_W'(prt_s5[k].pll);
		assign num = prt_s5[k].perp
			? (ssd_pkg::NUM_W'(c2) << (2 * ssd_pkg::FRAC_BITS))
			: (ssd_pkg::NUM_W'(prt_s5[k].e2) << (2 * ssd_pkg::FRAC_BITS));
		assign rem_c[k] = num[ssd_pkg::NUM_W-1:ssd_pkg::QW];
		assign qn_c[k]  = num[ssd_pkg::QW-1:0];
		assign den_c[k] = prt_s5[k].perp ? prt_s5[k].len2 : ssd_pkg::SQ_W'(1);

		ssd_div u_div (
			.clk    (clk),
			.en     (adv),
			.rem_in (rem_s6[k]),
			.qn_in  (qn_s6[k]),
			.den_in (den_s6[k]),
			.quo    (quo[k])
		);
	end

	// crossing, or an endpoint on the other segment
	assign touch_c = (~zero[0] & ~zero[1] & (neg[0] ^ neg[1])
			& ~zero[2] & ~zero[3] & (neg[2] ^ neg[3]))
		| (zero[0] & sum_s3[0].box) | (zero[1] & sum_s3[1].box)
		| (zero[2] & sum_s3[2].box) | (zero[3] & sum_s3[3].box);

	// front stage data registers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < L; k++) begin
				dif_s1[k] <= dif_c[k];
				prd_s2[k] <= prd_c[k];
				sum_s3[k] <= sum_c[k];
				sel_s4[k] <= sel_c[k];
				prt_s5[k] <= prt_c[k];
				rem_s6[k] <= rem_c[k];
				qn_s6[k]  <= qn_c[k];
				den_s6[k] <= den_c[k];
			end
			touch_s4 <= touch_c;
			touch_s5 <= touch_s4;
			touch_s6 <= touch_s5;
		end
	end

	// front stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// control line alongside divider, minimum and root stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssd_pkg::LAT; i++) begin
				ctl_s[i] <= '0;
			end
		end else if (adv) begin
			ctl_s[0] <= '{valid: v_s6, touch: touch_s6};
			for (int i = 1; i < ssd_pkg::LAT; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	// least of the four scaled squared distances
	always_ff @(posedge clk) begin
		if (adv) begin
			min01_sm1 <= (quo[1] < quo[0]) ? quo[1] : quo[0];
			min23_sm1 <= (quo[3] < quo[2]) ? quo[3] : quo[2];
			min_sm2   <= (min23_sm1 < min01_sm1) ? min23_sm1 : min01_sm1;
		end
	end

	ssd_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.op   (ssd_pkg::OP_W'(min_sm2)),
		.root (root)
	);

	// result
	assign rsp_valid = ctl_s[ssd_pkg::LAT-1].valid;
	assign touching  = ctl_s[ssd_pkg::LAT-1].touch;
	assign distance  = ctl_s[ssd_pkg::LAT-1].touch ? '0 : ssd_pkg::OUT_W'(root);

endmodule
